FILE: src/lsh_pkg.sv
// Shared types, constants and the per-pixel sharpening arithmetic for the
// 3x3 Laplacian sharpening filter. No dependencies.
package lsh_pkg;

    localparam int PIX_W         = 8;
    localparam int CFG_W         = 10;
    localparam int ROW_W         = 10;
    localparam int CFG_IDX_W     = 1;
    localparam int MAX_WIDTH_DEF = 512;
    localparam int MAX_HEIGHT    = 512;
    localparam int MIN_DIM       = 2;
    localparam int RESET_WIDTH   = 480;
    localparam int RESET_HEIGHT  = 272;
    localparam int FIFO_DEPTH    = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } t_cfg_reg;

    typedef logic [PIX_W-1:0] t_pix;

    typedef struct packed {
        t_pix sharp_pixel;
        logic last_of_frame;
    } t_result;

    // 4*c minus the four neighbors, clamped to 0..255, halved, added to the
    // centre and saturated at 255.
    function automatic t_pix sharpen(t_pix west, t_pix top, t_pix centre,
                                     t_pix bottom, t_pix east);
        logic signed [11:0] lap;
        logic [7:0]         lap_c;
        logic [8:0]         sum;
        lap = $signed({2'b00, centre, 2'b00})
            - $signed({4'b0000, top})
            - $signed({4'b0000, bottom})
            - $signed({4'b0000, west})
            - $signed({4'b0000, east});
        if (lap < 12'sd0) begin
            lap_c = 8'd0;
        end else if (lap > 12'sd255) begin
            lap_c = 8'hFF;
        end else begin
            lap_c = lap[7:0];
        end
        sum = {2'b00, lap_c[7:1]} + {1'b0, centre};
        return sum[8] ? 8'hFF : sum[7:0];
    endfunction

endpackage

FILE: src/lsh_if.sv
// Valid/ready channel interfaces for the sharpening filter: input pixels,
// sharpened results and configuration writes. Depends on lsh_pkg.
interface lsh_pix_if;
    logic                    valid;
    logic                    ready;
    logic [lsh_pkg::PIX_W-1:0] pixel;
    logic                    flush;
    modport source (output valid, output pixel, output flush, input ready);
    modport sink   (input valid, input pixel, input flush, output ready);
endinterface

interface lsh_res_if;
    logic                    valid;
    logic                    ready;
    logic [lsh_pkg::PIX_W-1:0] sharp_pixel;
    logic                    last_of_frame;
    modport source (output valid, output sharp_pixel, output last_of_frame, input ready);
    modport sink   (input valid, input sharp_pixel, input last_of_frame, output ready);
endinterface

interface lsh_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [lsh_pkg::CFG_IDX_W-1:0] index;
    logic [lsh_pkg::CFG_W-1:0]     data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: src/laplacian_sharpen_3x3.sv
// Results of accepted beats are queued and offered on o_res in order. Throughput:
// one input beat per cycle while the queue can hold two results; an end-of-row beat
// yields two results and the first beat of the next row none, so a four-entry result
// queue absorbs it. Output row r leaves while input row r+1 arrives; W flush beats
// drain the last row. Reset (synchronous, active low) clears counters, window and
// queue; the line buffer is not cleared and needs no clearing pass.
module laplacian_sharpen_3x3 #(
    parameter int MAX_WIDTH = lsh_pkg::MAX_WIDTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lsh_pix_if.sink    i_pix,
    lsh_res_if.source  o_res,
    lsh_cfg_if.sink    i_cfg
);

    localparam int IDX_W = $clog2(MAX_WIDTH);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int LW    = 2 * lsh_pkg::PIX_W;
    localparam int PTR_W = $clog2(lsh_pkg::FIFO_DEPTH);
    localparam int CNT_W = $clog2(lsh_pkg::FIFO_DEPTH + 1);

    // Configuration registers, stored raw and saturated on use.
    logic [lsh_pkg::CFG_W-1:0] r_img_width;
    logic [lsh_pkg::CFG_W-1:0] r_img_height;

    // Position in the frame.
    logic [IDX_W-1:0]          r_col, n_col;
    logic [lsh_pkg::ROW_W-1:0] r_row, n_row;
    logic [IDX_W-1:0]          r_drain, n_drain;

    // Window: only the mid pixel of the left column and the whole right
    // column must be kept to build the next two windows.
    lsh_pkg::t_pix r_c1_mid;
    lsh_pkg::t_pix r_c2_top, r_c2_mid, r_c2_bot;

    // Line buffer: each word holds {row two back, previous row} for a column.
    logic [LW-1:0]    r_line [MAX_WIDTH];
    logic [LW-1:0]    r_line_rd;
    logic [IDX_W-1:0] rd_addr;

    // Result queue.
    lsh_pkg::t_result r_fifo [lsh_pkg::FIFO_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    logic [WW-1:0]             eff_w, w_last;
    logic [lsh_pkg::ROW_W-1:0] eff_h;
    logic                      drain_mode, item_acc, cfg_acc, pop;
    logic [IDX_W-1:0]          col_x;
    logic                      at_last, first_col;
    lsh_pkg::t_pix             rd_prev, rd_prev2;
    lsh_pkg::t_pix             ld_top, ld_mid, ld_bot;
    logic                      do_load, do_write, emit_a, emit_b;
    lsh_pkg::t_result          res_a, res_b, slot0, slot1;
    logic [1:0]                n_push;

    // Saturate the frame size to the supported ranges.
    always_comb begin
        if (r_img_width < lsh_pkg::CFG_W'(lsh_pkg::MIN_DIM)) begin
            eff_w = WW'(lsh_pkg::MIN_DIM);
        end else if (int'(r_img_width) > MAX_WIDTH) begin
            eff_w = WW'(MAX_WIDTH);
        end else begin
            eff_w = WW'(r_img_width);
        end
        if (r_img_height < lsh_pkg::CFG_W'(lsh_pkg::MIN_DIM)) begin
            eff_h = lsh_pkg::ROW_W'(lsh_pkg::MIN_DIM);
        end else if (int'(r_img_height) > lsh_pkg::MAX_HEIGHT) begin
            eff_h = lsh_pkg::ROW_W'(lsh_pkg::MAX_HEIGHT);
        end else begin
            eff_h = lsh_pkg::ROW_W'(r_img_height);
        end
    end

    assign w_last     = eff_w - WW'(1);
    // Once all rows are in, only flush beats count: they replay the last row
    // as the bottom neighbor of itself.
    assign drain_mode = (r_row >= eff_h);
    assign item_acc   = i_pix.valid && i_pix.ready;
    assign cfg_acc    = i_cfg.valid && i_cfg.ready;
    assign pop        = o_res.valid && o_res.ready;

    assign col_x     = drain_mode ? r_drain : r_col;
    assign at_last   = (WW'(col_x) == w_last);
    assign first_col = (col_x == '0);

    // The line word for col_x was prefetched in the previous cycle.
    assign rd_prev  = r_line_rd[lsh_pkg::PIX_W-1:0];
    assign rd_prev2 = r_line_rd[LW-1:lsh_pkg::PIX_W];

    // New window column. While the second row of the frame arrives, the first row is
    // its own top neighbor; during the drain the last row is its own bottom.
    always_comb begin
        ld_mid = rd_prev;
        if (drain_mode) begin
            ld_top = rd_prev2;
            ld_bot = rd_prev;
        end else begin
            ld_top = (r_row == lsh_pkg::ROW_W'(1)) ? rd_prev : rd_prev2;
            ld_bot = i_pix.pixel;
        end
    end

    assign do_load  = item_acc && (drain_mode ? i_pix.flush
                                              : (!i_pix.flush && (r_row != '0)));
    assign do_write = item_acc && !drain_mode && !i_pix.flush;
    assign emit_a   = do_load && !first_col;
    assign emit_b   = do_load && at_last;

    // The first result is centered on the previous column; the extra one at
    // the end of a row is centered on the new column with the right edge
    // replicated.
    assign res_a.sharp_pixel   = lsh_pkg::sharpen(r_c1_mid, r_c2_top, r_c2_mid,
                                                  r_c2_bot, ld_mid);
    assign res_a.last_of_frame = 1'b0;
    assign res_b.sharp_pixel   = lsh_pkg::sharpen(r_c2_mid, ld_top, ld_mid,
                                                  ld_bot, ld_mid);
    assign res_b.last_of_frame = drain_mode;

    always_comb begin
        slot0  = emit_a ? res_a : res_b;
        slot1  = res_b;
        n_push = {1'b0, emit_a} + {1'b0, emit_b};
    end

    // Frame position. A configuration write starts a new frame.
    always_comb begin
        n_col   = r_col;
        n_row   = r_row;
        n_drain = r_drain;
        priority if (cfg_acc) begin
            n_col   = '0;
            n_row   = '0;
            n_drain = '0;
        end else if (item_acc && drain_mode && i_pix.flush) begin
            if (at_last) begin
                n_col   = '0;
                n_row   = '0;
                n_drain = '0;
            end else begin
                n_drain = r_drain + IDX_W'(1);
            end
        end else if (do_write) begin
            if (at_last) begin
                n_col   = '0;
                n_row   = r_row + lsh_pkg::ROW_W'(1);
                n_drain = '0;
            end else begin
                n_col = r_col + IDX_W'(1);
            end
        end else begin
            n_col = r_col;
        end
    end

    // Prefetch the word for the column the next beat will use. It differs from the
    // column written in that cycle unless a configuration write comes at column 0.
    assign rd_addr = (n_row >= eff_h) ? n_drain : n_col;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_width  <= lsh_pkg::CFG_W'(lsh_pkg::RESET_WIDTH);
            r_img_height <= lsh_pkg::CFG_W'(lsh_pkg::RESET_HEIGHT);
            r_col        <= '0;
            r_row        <= '0;
            r_drain      <= '0;
        end else begin
            r_col   <= n_col;
            r_row   <= n_row;
            r_drain <= n_drain;
            if (cfg_acc) begin
                unique case (i_cfg.index)
                    lsh_pkg::REG_IMAGE_WIDTH: begin
                        r_img_width <= i_cfg.data;
                    end
                    lsh_pkg::REG_IMAGE_HEIGHT: begin
                        r_img_height <= i_cfg.data;
                    end
                endcase
            end
        end
    end

    // Window registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c1_mid <= '0;
            r_c2_top <= '0;
            r_c2_mid <= '0;
            r_c2_bot <= '0;
        end else if (do_load) begin
            r_c1_mid <= first_col ? ld_mid : r_c2_mid;
            r_c2_top <= ld_top;
            r_c2_mid <= ld_mid;
            r_c2_bot <= ld_bot;
        end
    end

    // Line buffer: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (do_write) begin
            r_line[r_col] <= {rd_prev, i_pix.pixel};
        end
        r_line_rd <= r_line[rd_addr];
    end

    // Result queue payload.
    always_ff @(posedge i_clk) begin
        if (n_push != 2'd0) begin
            r_fifo[r_wr_ptr] <= slot0;
        end
        if (n_push == 2'd2) begin
            r_fifo[r_wr_ptr + PTR_W'(1)] <= slot1;
        end
    end

    // Result queue control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + PTR_W'(n_push);
            r_rd_ptr <= r_rd_ptr + PTR_W'(pop);
            r_count  <= r_count + CNT_W'(n_push) - CNT_W'(pop);
        end
    end

    // A beat is taken only when the queue can hold both of its results.
    assign i_pix.ready       = (r_count <= CNT_W'(lsh_pkg::FIFO_DEPTH - 2));
    assign i_cfg.ready       = 1'b1;
    assign o_res.valid       = (r_count != '0);
    assign o_res.sharp_pixel   = r_fifo[r_rd_ptr].sharp_pixel;
    assign o_res.last_of_frame = r_fifo[r_rd_ptr].last_of_frame;

    a_fifo_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(lsh_pkg::FIFO_DEPTH))
        else $error("result queue overflow");

    a_col_in_row : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        WW'(r_col) < eff_w)
        else $error("column counter beyond row width");

    a_drain_col : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        drain_mode |-> (r_col == '0) && (r_row == eff_h))
        else $error("inconsistent frame position while draining");

    a_frame_end : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (item_acc && drain_mode && i_pix.flush && at_last && !cfg_acc)
        |=> (r_row == '0) && (r_drain == '0) && (r_col == '0))
        else $error("frame position not cleared after the last drain beat");

endmodule
